@@ hdl/reversible_deque_defines.svh @@
// Assertion macros shared by the reversible deque RTL.
`ifndef REVERSIBLE_DEQUE_DEFINES_SVH
`define REVERSIBLE_DEQUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reversible_deque assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reversible_deque assertion failed");

`endif

@@ hdl/rdq_pkg.sv @@
// Package with the types and codes of the reversible deque.
package rdq_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REVERSE    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } out_beat_t;

endpackage

@@ hdl/reversible_deque.sv @@
// Reversible double-ended queue over a circular word store.
// A pop or a dropped push shows its result in the cycle after its input beat.
// Throughput: one operation per cycle while no result beat is stalled, set by the single
// write and read port of the store. Successful pushes and reverses produce no result beat.
// Synchronous active-low reset empties the queue and restores normal orientation.
// The word store has no reset and needs no clearing pass.
`include "reversible_deque_defines.svh"

module reversible_deque #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rdq_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rdq_pkg::out_beat_t out_data
);
  import rdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;

  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          res_valid_r, res_valid_nxt;
  logic [1:0]    res_status_r, res_status_nxt;

  logic          accept;
  logic          to_back;
  logic          full;
  logic          empty;
  logic          is_push;
  logic          is_pop;
  logic          is_rev;
  logic [IW-1:0] head_dec;
  logic [IW-1:0] head_inc;
  logic [SW-1:0] back_sum;
  logic [SW-1:0] last_sum;
  logic [IW-1:0] back_slot;
  logic [IW-1:0] last_slot;

  assign in_ready  = !res_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = res_valid_r;
  assign out_data.status    = res_status_r;
  assign out_data.pop_value = (res_status_r == ST_OK) ? signed'(rdata_r) : '0;
  assign is_push = (in_data.op == OP_PUSH_FRONT) || (in_data.op == OP_PUSH_BACK);
  assign is_pop  = (in_data.op == OP_POP_FRONT) || (in_data.op == OP_POP_BACK);
  assign is_rev  = (in_data.op == OP_REVERSE);

  always_comb begin
    to_back  = ((in_data.op == OP_PUSH_BACK) || (in_data.op == OP_POP_BACK)) ^ rev_r;
    full     = (count_r == CW'(DEPTH));
    empty    = (count_r == '0);
    head_dec = (head_r == '0) ? IW'(DEPTH - 1) : head_r - 1'b1;
    head_inc = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    back_sum = {1'b0, head_r} + SW'(count_r);
    last_sum = back_sum - 1'b1;
    back_slot = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
    last_slot = (last_sum >= SW'(DEPTH)) ? IW'(last_sum - SW'(DEPTH)) : IW'(last_sum);

    head_nxt       = head_r;
    count_nxt      = count_r;
    rev_nxt        = rev_r;
    res_valid_nxt  = res_valid_r && !out_ready;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = back_slot;
    mem_wdata      = in_data.push_value;
    mem_re         = 1'b0;
    mem_raddr      = head_r;

    if (accept) begin
      res_valid_nxt = 1'b0;
      unique case (in_data.op) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            if (to_back) begin
              mem_waddr = back_slot;
            end else begin
              mem_waddr = head_dec;
              head_nxt  = head_dec;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          res_valid_nxt = 1'b1;
          if (empty) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            res_status_nxt = ST_OK;
            mem_re         = 1'b1;
            count_nxt      = count_r - 1'b1;
            if (to_back) begin
              mem_raddr = last_slot;
            end else begin
              mem_raddr = head_r;
              head_nxt  = head_inc;
            end
          end
        end
        OP_REVERSE: begin
          rev_nxt = !rev_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  `RDQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `RDQ_ASSERT_NEXT(a_pop_empty, accept && is_pop && empty, out_valid && res_status_r == ST_EMPTY)
  `RDQ_ASSERT_NEXT(a_push_full, accept && is_push && full, out_valid && res_status_r == ST_FULL)
  `RDQ_ASSERT_NEXT(a_full_hold, accept && is_push && full, $stable(head_r) && $stable(count_r))
  `RDQ_ASSERT_NEXT(a_reverse, accept && is_rev, rev_r != $past(rev_r) && $stable(count_r))

endmodule

@@ verif/reversible_deque_tb.sv @@
// Self-checking testbench for the reversible deque with a scoreboard class and random stalls.
`timescale 1ns / 1ps

module reversible_deque_tb;
  import rdq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 400;

  class deque_scoreboard;
    logic signed [31:0] slots [DEPTH];
    int head;
    int count;
    bit flipped;
    out_beat_t pending [$];
    int errors;
    int n_words;
    int n_empty;
    int n_full;
    int peak;

    function new();
      head = 0;
      count = 0;
      flipped = 0;
      errors = 0;
      n_words = 0;
      n_empty = 0;
      n_full = 0;
      peak = 0;
    endfunction

    function void note_input(in_beat_t b);
      bit at_back;
      out_beat_t r;
      r.pop_value = '0;
      case (b.op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          at_back = (b.op == OP_PUSH_BACK) != flipped;
          if (count >= DEPTH) begin
            r.status = ST_FULL;
            pending.insert(pending.size(), r);
          end else begin
            if (at_back) begin
              slots[(head + count) % DEPTH] = b.push_value;
            end else begin
              head = (head + DEPTH - 1) % DEPTH;
              slots[head] = b.push_value;
            end
            count++;
            if (count > peak) peak = count;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          at_back = (b.op == OP_POP_BACK) != flipped;
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_OK;
            if (at_back) begin
              r.pop_value = slots[(head + count - 1) % DEPTH];
            end else begin
              r.pop_value = slots[head];
              head = (head + 1) % DEPTH;
            end
            count--;
          end
          pending.insert(pending.size(), r);
        end
        OP_REVERSE: flipped = !flipped;
        default: ;
      endcase
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual status %0d value %0d",
                 $time, r.status, r.pop_value);
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (r.status !== e.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, r.status);
      end
      if (r.pop_value !== e.pop_value) begin
        errors++;
        $display("%0t: pop_value mismatch, expected %0d, actual %0d",
                 $time, e.pop_value, r.pop_value);
      end
      case (e.status)
        ST_OK: n_words++;
        ST_EMPTY: n_empty++;
        default: n_full++;
      endcase
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  deque_scoreboard sb;
  int n_in = 0;
  int n_results = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  int rx_seen = 0;
  bit rx_calm = 1'b0;
  bit tx_calm;

  reversible_deque #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    bit busy;
    if (rst_n) begin
      busy = 0;
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
        n_in++;
        busy = 1;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        n_results++;
        busy = 1;
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (n_results != rx_seen)) begin
      rx_seen = n_results;
      if (n_results % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (n_results == 60) rx_hold = LONG_HOLD;
      else rx_hold = rx_calm ? 0 : $urandom_range(0, 8);
    end
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic signed [31:0] val);
    int gap;
    if (n_in % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, push_value: val};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int push_w, input int pop_w, input int rev_w);
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < push_w) op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    else if (r < push_w + pop_w) op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    else if (r < push_w + pop_w + rev_w) op = OP_REVERSE;
    else op = 3'($urandom_range(5, 7));
    send_beat(op, $urandom);
  endtask

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL reversible_deque");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sb = new();
    tx_calm = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(OP_POP_FRONT, $urandom);
    send_beat(OP_POP_BACK, $urandom);
    send_beat(OP_PUSH_FRONT, 32'sh7fffffff);
    send_beat(OP_PUSH_BACK, 32'sh80000000);
    send_beat(OP_PUSH_FRONT, 32'sh00000000);
    send_beat(OP_PUSH_BACK, -32'sd1);
    send_beat(OP_POP_FRONT, $urandom);
    send_beat(OP_POP_BACK, $urandom);
    send_beat(OP_REVERSE, $urandom);
    send_beat(OP_PUSH_FRONT, 32'sh55555555);
    send_beat(OP_PUSH_BACK, 32'shaaaaaaaa);
    send_beat(OP_POP_FRONT, $urandom);
    send_beat(OP_POP_BACK, $urandom);
    send_beat(3'd5, $urandom);
    send_beat(3'd6, $urandom);
    send_beat(3'd7, $urandom);
    send_beat(OP_REVERSE, $urandom);
    send_beat(OP_POP_FRONT, $urandom);
    send_beat(OP_POP_BACK, $urandom);
    send_beat(OP_POP_FRONT, $urandom);

    repeat (200) send_random(30, 40, 20);
    while (sb.count < DEPTH) send_random(95, 2, 2);
    repeat (40) send_random(80, 5, 10);
    repeat (300) send_random(35, 50, 10);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end

    $display("Sent %0d operation beats and checked %0d result beats, peak fill %0d of %0d.",
             n_in, n_results, sb.peak, DEPTH);
    $display("Results: %0d popped words, %0d pops on empty, %0d pushes dropped when full.",
             sb.n_words, sb.n_empty, sb.n_full);
    if (sb.errors == 0) begin
      $display("PASS reversible_deque");
    end else begin
      $display("FAIL reversible_deque");
    end
    $finish;
  end

endmodule
